>>> design/epd_pkg.sv
// shared types and constants for the encoder position drive block
// no dependencies; every other file refers to it by scoped names

package epd_pkg;

   // pwm period in timer ticks and encoder thresholds
   localparam int unsigned PWM_PERIOD     = 1000;
   localparam int unsigned WRAP_THRESHOLD = 1000;
   localparam int unsigned MOVE_THRESHOLD = 50;

   // power is carried in hundredths of a percent
   localparam int unsigned FULL_SCALE     = 10000;
   localparam int unsigned PCT_SCALE      = 100;
   localparam int unsigned MAX_CAP_PCT    = 100;
   localparam int unsigned MIN_MOVE_POWER = 50;

   localparam int unsigned POWER_W = 14;
   localparam int unsigned DUTY_W  = 16;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned DELTA_W = 17;
   localparam int unsigned ERR_W   = 33;
   localparam int unsigned CAP_W   = 7;

   // floor(x * PWM_PERIOD / FULL_SCALE) as (x * RECIP) >> RECIP_SHIFT,
   // exact for every x up to FULL_SCALE since FULL_SCALE^2 < 2^RECIP_SHIFT
   localparam int unsigned RECIP_SHIFT = 27;
   localparam int unsigned RECIP_W     = 30;
   localparam longint unsigned RECIP_FULL =
      ((longint'(PWM_PERIOD) << RECIP_SHIFT) + longint'(FULL_SCALE) - 1) /
      longint'(FULL_SCALE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
   localparam int unsigned PROD_W = POWER_W + RECIP_W;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POWER_CAP   = 2'd0,
      CSR_POLARITY    = 2'd1,
      CSR_PRIMARY_CH3 = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_SAMPLE     = 3'd0,
      OP_CONTROL    = 3'd1,
      OP_SET_TARGET = 3'd2,
      OP_ADD_TARGET = 3'd3,
      OP_SET_COUNT  = 3'd4,
      OP_MANUAL     = 3'd5
   } op_type;

   typedef struct packed {
      logic              forward;
      logic              reversed;
      logic [ERR_W-1:0]  power;
      logic [POWER_W-1:0] limit;
   } drive_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_primary;
      logic [DUTY_W-1:0] duty_secondary;
      logic              moving;
   } drive_rsp_type;

endpackage

>>> design/epd_ifs.sv
// channel interfaces of the encoder position drive block
// depends on epd_pkg for field widths

interface epd_req_if;
   logic                              valid;
   logic                              ready;
   logic [2:0]                        opcode;
   logic [15:0]                       encoder_count;
   logic signed [epd_pkg::POS_W-1:0]  operand_value;
   logic                              drive_forward;
   logic [epd_pkg::POWER_W-1:0]       drive_power;

   modport source (output valid, opcode, encoder_count, operand_value,
                   drive_forward, drive_power, input ready);
   modport sink (input valid, opcode, encoder_count, operand_value,
                 drive_forward, drive_power, output ready);
endinterface

interface epd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [epd_pkg::DUTY_W-1:0]         duty_primary;
   logic [epd_pkg::DUTY_W-1:0]         duty_secondary;
   logic signed [epd_pkg::POS_W-1:0]   total_count;
   logic signed [epd_pkg::POS_W-1:0]   target_position;
   logic signed [epd_pkg::DELTA_W-1:0] last_delta;
   logic                               moving;

   modport source (output valid, duty_primary, duty_secondary, total_count,
                   target_position, last_delta, moving, input ready);
   modport sink (input valid, duty_primary, duty_secondary, total_count,
                 target_position, last_delta, moving, output ready);
endinterface

interface epd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [epd_pkg::CSR_INDEX_W-1:0]    index;
   logic [epd_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/epd_drive.sv
// power to h-bridge compare conversion: clamp, scale to ticks, pick sides
// depends on epd_pkg

module epd_drive (
   input  epd_pkg::drive_req_type drive_req,
   output epd_pkg::drive_rsp_type drive_rsp
);

   logic [epd_pkg::POWER_W-1:0] clamped;
   logic [epd_pkg::POWER_W-1:0] headroom;
   logic [epd_pkg::PROD_W-1:0]  product;
   logic [epd_pkg::DUTY_W-1:0]  reduced;
   logic [epd_pkg::DUTY_W-1:0]  full;
   logic                        primary_full;

   always_comb begin
      if (drive_req.power > epd_pkg::ERR_W'(drive_req.limit)) begin
         clamped = drive_req.limit;
      end else begin
         clamped = drive_req.power[epd_pkg::POWER_W-1:0];
      end
      headroom = epd_pkg::POWER_W'(epd_pkg::FULL_SCALE) - clamped;
      product  = epd_pkg::PROD_W'(headroom) * epd_pkg::PROD_W'(epd_pkg::RECIP);
      reduced  = product[epd_pkg::RECIP_SHIFT +: epd_pkg::DUTY_W];
      full     = epd_pkg::DUTY_W'(epd_pkg::PWM_PERIOD);
      // reversed polarity swaps which bridge side sees the reduced compare
      primary_full = drive_req.forward ^ drive_req.reversed;

      drive_rsp.duty_primary   = primary_full ? full : reduced;
      drive_rsp.duty_secondary = primary_full ? reduced : full;
      // motion is judged on the requested power, before the cap
      drive_rsp.moving = drive_req.power >= epd_pkg::ERR_W'(epd_pkg::MIN_MOVE_POWER);
   end

endmodule

>>> design/encoder_position_p_drive_top.sv
// top level of the encoder position drive block: input register, state update, result register
// depends on epd_pkg, the channel interfaces in epd_ifs and epd_drive

// Each request beat carries one opcode: encoder sample, control update, set or add target,
// set count, or manual drive; every accepted beat returns exactly one response beat showing the
// position, target, last delta, motion flag and both h-bridge compare values after the step.
// One beat is accepted every clock cycle while the response side does not stall; a beat
// passes through the input register, the state update and the result register before its
// response is presented. Stalls on the response side hold both registers and back-pressure
// the request side.
// Configuration writes are always ready; the primary channel select register only steers timer
// routing outside this block and does not change any compare value.

module encoder_position_p_drive_top (
   input logic         clock,
   input logic         reset,
   epd_req_if.sink     req_bus,
   epd_rsp_if.source   rsp_bus,
   epd_csr_if.sink     csr_bus
);

   // configuration
   logic [epd_pkg::POWER_W-1:0] cap_limit_ff;
   logic                        reversed_ff;
   logic [epd_pkg::CAP_W-1:0]   cap_pct;

   // input register
   logic                              in_valid_ff;
   logic [2:0]                        in_opcode_ff;
   logic [15:0]                       in_encoder_ff;
   logic signed [epd_pkg::POS_W-1:0]  in_operand_ff;
   logic                              in_forward_ff;
   logic [epd_pkg::POWER_W-1:0]       in_power_ff;

   // block state
   logic [15:0]                        prev_encoder_ff, prev_encoder_in;
   logic signed [epd_pkg::POS_W-1:0]   total_ff, total_in;
   logic signed [epd_pkg::POS_W-1:0]   target_ff, target_in;
   logic signed [epd_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic                               moving_ff, moving_in;
   logic [epd_pkg::DUTY_W-1:0]         duty_pri_ff, duty_pri_in;
   logic [epd_pkg::DUTY_W-1:0]         duty_sec_ff, duty_sec_in;

   // result register
   logic rsp_valid_ff;

   logic advance;
   logic fire;

   logic signed [epd_pkg::DELTA_W-1:0] delta_raw;
   logic signed [epd_pkg::DELTA_W-1:0] delta_adj;
   logic signed [epd_pkg::ERR_W-1:0]   pos_error;
   logic [epd_pkg::ERR_W-1:0]          error_mag;
   epd_pkg::drive_req_type             drive_req;
   epd_pkg::drive_rsp_type             drive_rsp;

   localparam logic signed [epd_pkg::DELTA_W-1:0] WRAP_POS =
      epd_pkg::DELTA_W'(epd_pkg::WRAP_THRESHOLD);
   localparam logic signed [epd_pkg::DELTA_W-1:0] MOVE_POS =
      epd_pkg::DELTA_W'(epd_pkg::MOVE_THRESHOLD);

   // handshake
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;

   // configuration writes
   assign cap_pct = csr_bus.data[epd_pkg::CAP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_limit_ff <= epd_pkg::POWER_W'(epd_pkg::FULL_SCALE);
         reversed_ff  <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            epd_pkg::CSR_POWER_CAP: begin
               // cap kept as a limit in hundredths of a percent, saturated at full scale
               if (cap_pct > epd_pkg::CAP_W'(epd_pkg::MAX_CAP_PCT)) begin
                  cap_limit_ff <= epd_pkg::POWER_W'(epd_pkg::FULL_SCALE);
               end else begin
                  cap_limit_ff <= epd_pkg::POWER_W'(cap_pct) *
                                  epd_pkg::POWER_W'(epd_pkg::PCT_SCALE);
               end
            end
            epd_pkg::CSR_POLARITY: begin
               reversed_ff <= csr_bus.data[0];
            end
            epd_pkg::CSR_PRIMARY_CH3: begin
               // channel routing lives in the timer setup, nothing to hold here
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_opcode_ff  <= req_bus.opcode;
         in_encoder_ff <= req_bus.encoder_count;
         in_operand_ff <= req_bus.operand_value;
         in_forward_ff <= req_bus.drive_forward;
         in_power_ff   <= req_bus.drive_power;
      end
   end

   // sample and control arithmetic
   always_comb begin
      delta_raw = $signed({1'b0, in_encoder_ff}) - $signed({1'b0, prev_encoder_ff});
      // +65536 and -65536 are the same change modulo 2^17: flip the top bit
      if (delta_raw < -WRAP_POS || delta_raw > WRAP_POS) begin
         delta_adj = {~delta_raw[epd_pkg::DELTA_W-1], delta_raw[epd_pkg::DELTA_W-2:0]};
      end else begin
         delta_adj = delta_raw;
      end

      pos_error = epd_pkg::ERR_W'(target_ff) - epd_pkg::ERR_W'(total_ff);
      error_mag = pos_error[epd_pkg::ERR_W-1] ? epd_pkg::ERR_W'(-pos_error)
                                              : epd_pkg::ERR_W'(pos_error);

      drive_req.reversed = reversed_ff;
      drive_req.limit    = cap_limit_ff;
      if (in_opcode_ff == epd_pkg::OP_MANUAL) begin
         drive_req.forward = in_forward_ff;
         drive_req.power   = epd_pkg::ERR_W'(in_power_ff);
      end else begin
         drive_req.forward = !pos_error[epd_pkg::ERR_W-1];
         drive_req.power   = error_mag;
      end
   end

   epd_drive u_drive (
      .drive_req (drive_req),
      .drive_rsp (drive_rsp)
   );

   // next state
   always_comb begin
      prev_encoder_in = prev_encoder_ff;
      total_in        = total_ff;
      target_in       = target_ff;
      delta_in        = delta_ff;
      moving_in       = moving_ff;
      duty_pri_in     = duty_pri_ff;
      duty_sec_in     = duty_sec_ff;
      case (in_opcode_ff)
         epd_pkg::OP_SAMPLE: begin
            prev_encoder_in = in_encoder_ff;
            total_in        = total_ff + epd_pkg::POS_W'(delta_adj);
            delta_in        = delta_adj;
            moving_in       = delta_adj > MOVE_POS || delta_adj < -MOVE_POS;
         end
         epd_pkg::OP_CONTROL, epd_pkg::OP_MANUAL: begin
            duty_pri_in = drive_rsp.duty_primary;
            duty_sec_in = drive_rsp.duty_secondary;
            moving_in   = drive_rsp.moving;
         end
         epd_pkg::OP_SET_TARGET: begin
            target_in = in_operand_ff;
         end
         epd_pkg::OP_ADD_TARGET: begin
            target_in = target_ff + in_operand_ff;
         end
         epd_pkg::OP_SET_COUNT: begin
            total_in = in_operand_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_encoder_ff <= '0;
         total_ff        <= '0;
         target_ff       <= '0;
         delta_ff        <= '0;
         moving_ff       <= 1'b0;
         duty_pri_ff     <= '0;
         duty_sec_ff     <= '0;
      end else if (fire) begin
         prev_encoder_ff <= prev_encoder_in;
         total_ff        <= total_in;
         target_ff       <= target_in;
         delta_ff        <= delta_in;
         moving_ff       <= moving_in;
         duty_pri_ff     <= duty_pri_in;
         duty_sec_ff     <= duty_sec_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_bus.duty_primary    <= duty_pri_in;
         rsp_bus.duty_secondary  <= duty_sec_in;
         rsp_bus.total_count     <= total_in;
         rsp_bus.target_position <= target_in;
         rsp_bus.last_delta      <= delta_in;
         rsp_bus.moving          <= moving_in;
      end
   end

   // a held input beat is not dropped while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input beat lost during response stall");

   // the effective cap never exceeds full scale
   assert property (@(posedge clock) disable iff (reset)
      cap_limit_ff <= epd_pkg::POWER_W'(epd_pkg::FULL_SCALE))
      else $error("power limit above full scale");

   // one bridge side is always at the full period once any drive happened
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bus.duty_primary == epd_pkg::DUTY_W'(epd_pkg::PWM_PERIOD) ||
                        rsp_bus.duty_secondary == epd_pkg::DUTY_W'(epd_pkg::PWM_PERIOD) ||
                        (rsp_bus.duty_primary == '0 && rsp_bus.duty_secondary == '0)))
      else $error("neither bridge side at full period");

   // a sample moves the total by exactly the recorded delta
   assert property (@(posedge clock) disable iff (reset)
      fire && in_opcode_ff == epd_pkg::OP_SAMPLE |=>
         total_ff == $past(total_ff) + epd_pkg::POS_W'(delta_ff))
      else $error("total not advanced by sample delta");

endmodule

>>> tb/tb_encoder_position_p_drive_top.sv
// self-checking testbench for encoder_position_p_drive_top: directed table, then random phases
// depends on epd_pkg, the channel interfaces in epd_ifs and the design under test

module tb_encoder_position_p_drive_top;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [epd_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint ENC_SPAN = 65536;

   localparam int unsigned RESET_CYCLES  = 10;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned TAIL_CYCLES   = 8;
   localparam int unsigned DRAIN_LIMIT   = 20000;
   localparam int unsigned PHASES        = 10;
   localparam int unsigned PHASE_ITEMS   = 125;
   localparam int unsigned DIRECTED_ROWS = 26;
   localparam longint unsigned LIMIT_TIME = 5000000;

   localparam int unsigned PHASE_CAP [6] = '{0, 127, 1, 100, 50, 101};
   localparam bit PHASE_REV [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam bit PHASE_CH3 [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   typedef struct {
      logic [2:0]                   op;
      logic [15:0]                  enc;
      logic signed [31:0]           operand;
      logic                         fwd;
      logic [epd_pkg::POWER_W-1:0]  power;
   } drive_cmd_type;

   typedef struct {
      logic [epd_pkg::DUTY_W-1:0]          duty_primary;
      logic [epd_pkg::DUTY_W-1:0]          duty_secondary;
      logic signed [epd_pkg::POS_W-1:0]    total_count;
      logic signed [epd_pkg::POS_W-1:0]    target_position;
      logic signed [epd_pkg::DELTA_W-1:0]  last_delta;
      logic                                moving;
   } drive_state_type;

   typedef struct {
      bit               on;
      drive_state_type  want;
   } pinned_type;

   typedef struct {
      drive_cmd_type    cmd;
      bit               pinned;
      drive_state_type  want;
   } drive_row_type;

   logic clock;
   logic reset;

   epd_req_if req_bus ();
   epd_rsp_if rsp_bus ();
   epd_csr_if csr_bus ();

   encoder_position_p_drive_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted block state and registers
   logic [15:0]                        last_enc;
   logic signed [epd_pkg::POS_W-1:0]   track_total;
   logic signed [epd_pkg::POS_W-1:0]   track_target;
   logic signed [epd_pkg::DELTA_W-1:0] track_delta;
   logic                               track_moving;
   logic [epd_pkg::DUTY_W-1:0]         duty_main;
   logic [epd_pkg::DUTY_W-1:0]         duty_aux;
   logic [epd_pkg::CAP_W-1:0]          cap_pct;
   logic                               reversed;
   logic                               ch3_sel;

   drive_state_type expected_states [$];
   pinned_type      pinned_states [$];
   int unsigned     errors = 0;

   // stimulus side tracking, only used to keep random values near the live position
   logic [15:0] gen_enc = '0;
   int          gen_total = 0;

   bit rx_idle = 1'b1;
   bit hold_rsp = 1'b0;

   // rows with pinned results can be read straight off the reset state
   drive_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{OP_SPARE_LO, 16'hFFFF, -1, 1'b1, 14'h3FFF}, 1'b1, '{default: 0}},
      '{'{epd_pkg::OP_CONTROL, 16'd0, 0, 1'b0, 14'd0}, 1'b1,
        '{16'd1000, 16'd1000, 0, 0, 0, 1'b0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd50, 0, 1'b0, 14'd0}, 1'b1,
        '{16'd1000, 16'd1000, 50, 0, 50, 1'b0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd101, 0, 1'b0, 14'd0}, 1'b1,
        '{16'd1000, 16'd1000, 101, 0, 51, 1'b1}},
      '{'{epd_pkg::OP_SAMPLE, 16'd1101, 0, 1'b0, 14'd0}, 1'b1,
        '{16'd1000, 16'd1000, 1101, 0, 1000, 1'b1}},
      '{'{epd_pkg::OP_SAMPLE, 16'd2102, 0, 1'b0, 14'd0}, 1'b1,
        '{16'd1000, 16'd1000, -63434, 0, -64535, 1'b1}},
      // wrap in both directions and the threshold edges
      '{'{epd_pkg::OP_SAMPLE, 16'd65535, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd0, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd64535, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd63535, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd62534, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      // position total wrapping past the signed extremes
      '{'{epd_pkg::OP_SET_COUNT, 16'd0, 32'h7FFF_FFFF, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SAMPLE, 16'd63534, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SET_COUNT, 16'd0, 32'h7FFF_FFFF, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SET_TARGET, 16'd0, 32'h8000_0000, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_CONTROL, 16'd0, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_ADD_TARGET, 16'd0, -1, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SET_COUNT, 16'd0, 32'h8000_0000, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_CONTROL, 16'd0, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_ADD_TARGET, 16'd0, 32'h8000_0000, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_SET_COUNT, 16'd0, -1, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      // zero error drives forward with no power
      '{'{epd_pkg::OP_CONTROL, 16'd0, 0, 1'b0, 14'd0}, 1'b0, '{default: 0}},
      // manual drive around the motion limit and beyond full scale
      '{'{epd_pkg::OP_MANUAL, 16'd0, 0, 1'b0, 14'd49}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_MANUAL, 16'd0, 0, 1'b0, 14'd50}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_MANUAL, 16'd0, 0, 1'b1, 14'd10000}, 1'b0, '{default: 0}},
      '{'{epd_pkg::OP_MANUAL, 16'd0, 0, 1'b0, 14'h3FFF}, 1'b0, '{default: 0}}
   };

   function automatic void drive_bridge(input logic fwd,
                                        input logic [epd_pkg::ERR_W-1:0] power);
      logic [epd_pkg::ERR_W-1:0]  lim;
      logic [epd_pkg::ERR_W-1:0]  p;
      longint unsigned            reduced;
      logic                       main_full;
      lim = epd_pkg::ERR_W'(((cap_pct > epd_pkg::MAX_CAP_PCT) ? epd_pkg::MAX_CAP_PCT : cap_pct)
                            * epd_pkg::PCT_SCALE);
      p = (power > lim) ? lim : power;
      reduced = (longint'(epd_pkg::FULL_SCALE) - longint'(p)) * epd_pkg::PWM_PERIOD /
                epd_pkg::FULL_SCALE;
      main_full = fwd ^ reversed;
      duty_main = main_full ? epd_pkg::DUTY_W'(epd_pkg::PWM_PERIOD) : epd_pkg::DUTY_W'(reduced);
      duty_aux = main_full ? epd_pkg::DUTY_W'(reduced) : epd_pkg::DUTY_W'(epd_pkg::PWM_PERIOD);
      track_moving = (power >= epd_pkg::MIN_MOVE_POWER);
   endfunction

   function automatic drive_state_type next_state(input drive_cmd_type cmd);
      drive_state_type s;
      longint          d;
      longint          err;
      case (cmd.op)
         epd_pkg::OP_SAMPLE: begin
            d = longint'(cmd.enc) - longint'(last_enc);
            if (d < -longint'(epd_pkg::WRAP_THRESHOLD)) d = d + ENC_SPAN;
            else if (d > longint'(epd_pkg::WRAP_THRESHOLD)) d = d - ENC_SPAN;
            track_total = track_total + 32'(d);
            last_enc = cmd.enc;
            track_delta = epd_pkg::DELTA_W'(d);
            track_moving = ((d < 0) ? -d : d) > longint'(epd_pkg::MOVE_THRESHOLD);
         end
         epd_pkg::OP_CONTROL: begin
            err = longint'(track_target) - longint'(track_total);
            if (err < 0) drive_bridge(1'b0, epd_pkg::ERR_W'(-err));
            else drive_bridge(1'b1, epd_pkg::ERR_W'(err));
         end
         epd_pkg::OP_SET_TARGET: track_target = cmd.operand;
         epd_pkg::OP_ADD_TARGET: track_target = track_target + cmd.operand;
         epd_pkg::OP_SET_COUNT:  track_total = cmd.operand;
         epd_pkg::OP_MANUAL:     drive_bridge(cmd.fwd, epd_pkg::ERR_W'(cmd.power));
         default: ;
      endcase
      s.duty_primary = duty_main;
      s.duty_secondary = duty_aux;
      s.total_count = track_total;
      s.target_position = track_target;
      s.last_delta = track_delta;
      s.moving = track_moving;
      return s;
   endfunction

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly small encoder steps and targets near the position, so control is often unsaturated
   function automatic drive_cmd_type make_cmd();
      drive_cmd_type c;
      int unsigned   pick;
      int unsigned   sel;
      int            step;
      c.op = epd_pkg::OP_SAMPLE;
      c.enc = 16'($urandom);
      c.operand = $urandom;
      c.fwd = 1'($urandom);
      c.power = epd_pkg::POWER_W'($urandom);
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      if (pick < 40) begin
         if (sel == 0) begin
            gen_enc = c.enc;
         end else begin
            step = (sel == 1) ? int'($urandom_range(990, 1010)) : int'($urandom_range(0, 120));
            if ($urandom_range(0, 1) == 1) step = -step;
            c.enc = gen_enc + 16'(step);
            gen_enc = c.enc;
            gen_total = gen_total + step;
         end
      end else if (pick < 60) begin
         c.op = epd_pkg::OP_CONTROL;
      end else if (pick < 70) begin
         c.op = epd_pkg::OP_SET_TARGET;
         if (sel != 0) c.operand = gen_total + int'($urandom_range(0, 30000)) - 15000;
      end else if (pick < 78) begin
         c.op = epd_pkg::OP_ADD_TARGET;
         if (sel != 0) c.operand = int'($urandom_range(0, 10000)) - 5000;
      end else if (pick < 84) begin
         c.op = epd_pkg::OP_SET_COUNT;
         if (sel != 0) c.operand = gen_total + int'($urandom_range(0, 4000)) - 2000;
         gen_total = c.operand;
      end else if (pick < 97) begin
         c.op = epd_pkg::OP_MANUAL;
         if (sel < 4) c.power = epd_pkg::POWER_W'($urandom_range(0, 100));
         else if (sel < 8) c.power = epd_pkg::POWER_W'($urandom_range(0, epd_pkg::FULL_SCALE));
      end else begin
         c.op = (sel < 5) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      return c;
   endfunction

   task automatic send_cmd(input drive_cmd_type cmd, input bit idle);
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.opcode <= cmd.op;
      req_bus.encoder_count <= cmd.enc;
      req_bus.operand_value <= cmd.operand;
      req_bus.drive_forward <= cmd.fwd;
      req_bus.drive_power <= cmd.power;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pick_gap(idle);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [epd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [epd_pkg::CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      int unsigned waited;
      req_bus.valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (expected_states.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         errors++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_TIME);
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int unsigned stall;
      forever begin
         stall = hold_rsp ? HOLD_CYCLES : pick_gap(rx_idle);
         hold_rsp = 1'b0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : scoreboard
      drive_cmd_type   seen;
      drive_state_type got;
      drive_state_type want;
      pinned_type      tag;
      if (reset) begin
         last_enc = '0;
         track_total = '0;
         track_target = '0;
         track_delta = '0;
         track_moving = 1'b0;
         duty_main = '0;
         duty_aux = '0;
         cap_pct = epd_pkg::CAP_W'(epd_pkg::MAX_CAP_PCT);
         reversed = 1'b0;
         ch3_sel = 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               epd_pkg::CSR_POWER_CAP:   cap_pct = csr_bus.data;
               epd_pkg::CSR_POLARITY:    reversed = csr_bus.data[0];
               epd_pkg::CSR_PRIMARY_CH3: ch3_sel = csr_bus.data[0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.duty_primary = rsp_bus.duty_primary;
            got.duty_secondary = rsp_bus.duty_secondary;
            got.total_count = rsp_bus.total_count;
            got.target_position = rsp_bus.target_position;
            got.last_delta = rsp_bus.last_delta;
            got.moving = rsp_bus.moving;
            if (expected_states.size() == 0) begin
               $error("result beat with nothing expected");
               errors++;
            end else begin
               want = expected_states.pop_front();
               check_field("duty_primary", want.duty_primary, got.duty_primary);
               check_field("duty_secondary", want.duty_secondary, got.duty_secondary);
               check_field("total_count", want.total_count, got.total_count);
               check_field("target_position", want.target_position, got.target_position);
               check_field("last_delta", want.last_delta, got.last_delta);
               check_field("moving", want.moving, got.moving);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.op = req_bus.opcode;
            seen.enc = req_bus.encoder_count;
            seen.operand = req_bus.operand_value;
            seen.fwd = req_bus.drive_forward;
            seen.power = req_bus.drive_power;
            want = next_state(seen);
            tag.on = 1'b0;
            if (pinned_states.size() != 0) tag = pinned_states.pop_front();
            expected_states.push_back(tag.on ? tag.want : want);
         end
      end
   end

   initial begin
      int unsigned   phase;
      int unsigned   n;
      drive_cmd_type cmd;
      pinned_type    no_pin;
      bit            tx_idle;
      bit            rev;
      bit            ch3;
      logic [epd_pkg::CAP_W-1:0] cap;

      no_pin.on = 1'b0;
      no_pin.want = '{default: 0};
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= '0;
      req_bus.encoder_count <= '0;
      req_bus.operand_value <= '0;
      req_bus.drive_forward <= 1'b0;
      req_bus.drive_power <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         pinned_states.push_back('{directed_rows[n].pinned, directed_rows[n].want});
         send_cmd(directed_rows[n].cmd, 1'b1);
      end
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < 6) begin
            cap = epd_pkg::CAP_W'(PHASE_CAP[phase]);
            rev = PHASE_REV[phase];
            ch3 = PHASE_CH3[phase];
         end else begin
            cap = epd_pkg::CAP_W'($urandom_range(0, 127));
            rev = 1'($urandom);
            ch3 = 1'($urandom);
         end
         write_reg(epd_pkg::CSR_POWER_CAP, cap);
         write_reg(epd_pkg::CSR_POLARITY, {6'($urandom), rev});
         write_reg(epd_pkg::CSR_PRIMARY_CH3, {6'($urandom), ch3});
         // writes past the register list must leave everything alone
         if (phase % 2 == 0) write_reg(CSR_SPARE, 7'($urandom));

         tx_idle = (phase % 3 != 2);
         rx_idle = (phase % 4 != 3);
         if (phase % 4 == 1) hold_rsp = 1'b1;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            cmd = make_cmd();
            pinned_states.push_back(no_pin);
            send_cmd(cmd, tx_idle);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_states.size() != 0) begin
         $error("%0d result beats never arrived", expected_states.size());
         errors++;
      end
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
